[hw/rtl/sbm_pkg.sv]
// sbm_pkg: types, codes and constants shared by the break monitor modules
// no dependencies
package sbm_pkg;

  localparam int SECONDS_W = 14;
  localparam int ALARM_W   = 8;
  localparam int HOLD_W    = 3;
  localparam int INT_W     = 10;
  localparam int LED_W     = 7;
  localparam int SUM_W     = 18;
  localparam int COUNT_W   = 8;
  localparam int AVG_W     = 10;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int MAG_W     = 17;

  localparam logic [SECONDS_W-1:0] SECONDS_MAX       = 14'd16383;
  localparam logic [ALARM_W-1:0]   ALARM_SECONDS_MAX = 8'd255;
  localparam logic [HOLD_W-1:0]    HOLD_SAT          = 3'd7;
  localparam int                   SECONDS_PER_MIN   = 60;
  localparam int                   WALK_GRACE_S      = 3;

  // intensity = sum / 100 as (sum * RECIP_100) >> RECIP_100_SHIFT, exact for sum < 2^17
  localparam logic [17:0] RECIP_100       = 18'd167773;
  localparam int          RECIP_100_SHIFT = 24;
  // led = (i - 10) * 100 / 490 as ((i - 10) * LED_RECIP) >> LED_SHIFT, exact for i < 1024
  localparam logic [15:0] LED_RECIP       = 16'd53500;
  localparam int          LED_SHIFT       = 18;
  localparam logic [INT_W-1:0] LED_OFFSET = 10'd10;
  localparam logic [LED_W-1:0] LED_MAX    = 7'd100;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [9:0] RST_THRESHOLD    = 10'd250;
  localparam logic [7:0] RST_SIT_MINUTES  = 8'd30;
  localparam logic [2:0] RST_WALK_MINUTES = 3'd1;
  localparam logic [7:0] RST_MUTE_DELAY   = 8'd3;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD    = 2'd0,
    CFG_SIT_MINUTES  = 2'd1,
    CFG_WALK_MINUTES = 2'd2,
    CFG_MUTE_DELAY   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_SIT   = 2'd0,
    ST_ALARM = 2'd1,
    ST_WALK  = 2'd2
  } stage_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_ALARM_START  = 3'd1,
    EV_WALK_START   = 3'd2,
    EV_SUFFICIENT   = 3'd3,
    EV_INSUFFICIENT = 3'd4,
    EV_MUTED        = 3'd5
  } event_t;

  typedef enum logic {
    BK_RUN = 1'b0,
    BK_DIV = 1'b1
  } back_mode_t;

  typedef struct packed {
    logic               opcode;
    logic               button_pressed;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       stage_now;
    logic             sound_on;
    logic [2:0]       event_code;
    logic [AVG_W-1:0] activity_average;
    logic [LED_W-1:0] led_level;
  } out_item_t;

  // classified request as it sits in the queue
  typedef struct packed {
    logic             opcode;
    logic             button_pressed;
    logic [INT_W-1:0] intensity;
    logic [LED_W-1:0] led;
  } q_item_t;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

[hw/rtl/sbm_front.sv]
// sbm_front: three-stage front pipeline, gyro magnitude, intensity and led level
// depends on sbm_pkg; feeds sbm_queue
module sbm_front
  import sbm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     push,
  output q_item_t  push_item,
  input  logic     q_full
);

  function automatic logic [MAG_W-1:0] mag16(input logic signed [15:0] v);
    mag16 = v[15] ? ({1'b0, ~v} + 17'd1) : {1'b0, v};
  endfunction

  logic                  move;
  logic                  s1_valid, s2_valid, s3_valid;
  logic                  s1_op, s2_op, s3_op;
  logic                  s1_btn, s2_btn, s3_btn;
  logic [MAG_W-1:0]      s1_sum;
  logic [INT_W-1:0]      s2_int, s3_int;
  logic [LED_W-1:0]      s3_led;
  logic [MAG_W-1:0]      mag_sum;
  logic [34:0]           int_prod;
  logic [INT_W-1:0]      int_val;
  logic [INT_W-1:0]      led_diff;
  logic [25:0]           led_prod;
  logic [7:0]            led_raw;
  logic [LED_W-1:0]      led_val;

  assign move     = !s3_valid || !q_full;
  assign in_stall = !move;

  assign mag_sum = mag16(in_data.gyro_x) + mag16(in_data.gyro_y) + mag16(in_data.gyro_z);

  assign int_prod = 35'(s1_sum) * 35'(RECIP_100);
  assign int_val  = INT_W'(int_prod >> RECIP_100_SHIFT);

  assign led_diff = (s2_int > LED_OFFSET) ? (s2_int - LED_OFFSET) : '0;
  assign led_prod = 26'(led_diff) * 26'(LED_RECIP);
  assign led_raw  = 8'(led_prod >> LED_SHIFT);
  assign led_val  = (led_raw > 8'(LED_MAX)) ? LED_MAX : LED_W'(led_raw);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (move) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      s1_op  <= in_data.opcode;
      s1_btn <= in_data.button_pressed;
      s1_sum <= mag_sum;
      s2_op  <= s1_op;
      s2_btn <= s1_btn;
      s2_int <= int_val;
      s3_op  <= s2_op;
      s3_btn <= s2_btn;
      s3_int <= s2_int;
      s3_led <= led_val;
    end
  end

  assign push                     = s3_valid && !q_full;
  assign push_item.opcode         = s3_op;
  assign push_item.button_pressed = s3_btn;
  assign push_item.intensity      = s3_int;
  assign push_item.led            = s3_led;

endmodule

[hw/rtl/sbm_queue.sv]
// sbm_queue: short fifo of classified requests between front and back
// depends on sbm_pkg
module sbm_queue
  import sbm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    empty,
  output q_item_t head
);

  localparam int QW = $clog2(QUEUE_DEPTH);

  q_item_t         entries [QUEUE_DEPTH];
  logic [QW-1:0]   wr_ptr, rd_ptr;
  logic [QW:0]     count;

  assign full  = (count == (QW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // depth is a power of two, pointers wrap on their own
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule

[hw/rtl/sbm_divider.sv]
// sbm_divider: restoring divider, one quotient bit per cycle, for the walk average
// depends on sbm_pkg
module sbm_divider
  import sbm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [4:0] LAST_STEP = 5'(SUM_W - 1);

  logic               busy, done;
  logic [4:0]         step;
  logic [COUNT_W-1:0] rem;
  logic [SUM_W-1:0]   quo;
  logic [COUNT_W-1:0] dvs;
  logic [COUNT_W:0]   shifted;
  logic               fits;

  assign shifted = {rem, quo[SUM_W-1]};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? COUNT_W'(shifted - {1'b0, dvs}) : shifted[COUNT_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

[hw/rtl/sbm_back.sv]
// sbm_back: stage controller, timers, walk accumulation and result register
// depends on sbm_pkg; drives sbm_divider, pops sbm_queue
module sbm_back
  import sbm_pkg::*;
#(
  parameter int SAMPLE_PERIOD_S = 2,
  parameter int MAX_READINGS    = 150,
  parameter int HOLD_SECONDS    = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 q_empty,
  input  q_item_t              q_head,
  output logic                 pop,
  output div_req_t             div_req,
  input  div_rsp_t             div_rsp,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  localparam int PW = (SAMPLE_PERIOD_S > 1) ? $clog2(SAMPLE_PERIOD_S) : 1;
  localparam int unsigned RAW_TARGET [8] = '{
    0,
    1 * SECONDS_PER_MIN / SAMPLE_PERIOD_S,
    2 * SECONDS_PER_MIN / SAMPLE_PERIOD_S,
    3 * SECONDS_PER_MIN / SAMPLE_PERIOD_S,
    4 * SECONDS_PER_MIN / SAMPLE_PERIOD_S,
    5 * SECONDS_PER_MIN / SAMPLE_PERIOD_S,
    6 * SECONDS_PER_MIN / SAMPLE_PERIOD_S,
    7 * SECONDS_PER_MIN / SAMPLE_PERIOD_S
  };

  logic [9:0] walk_threshold;
  logic [7:0] sitting_minutes;
  logic [2:0] walking_minutes;
  logic [7:0] mute_delay;

  back_mode_t         mode, mode_next;
  stage_t             stage, stage_next;
  logic [SECONDS_W-1:0] stage_seconds, stage_seconds_next;
  logic [PW-1:0]      phase, phase_next;
  logic [ALARM_W-1:0] alarm_seconds, alarm_seconds_next;
  logic               sound_enabled, sound_enabled_next;
  logic               hold_pending, hold_pending_next;
  logic [HOLD_W-1:0]  hold_seconds, hold_seconds_next;
  logic [INT_W-1:0]   intensity_latest, intensity_latest_next;
  logic [LED_W-1:0]   led_latest, led_latest_next;
  logic [SUM_W-1:0]   activity_sum, activity_sum_next;
  logic [COUNT_W-1:0] reading_count, reading_count_next;
  logic [AVG_W-1:0]   last_average, last_average_next;
  logic               out_valid_next;
  out_item_t          out_data_next;

  logic               out_free;
  logic               emit;
  event_t             ev;
  logic               enter;
  stage_t             enter_target;
  logic [SECONDS_W-1:0] ss_inc;
  logic [PW-1:0]      phase_inc;
  logic [HOLD_W-1:0]  hs_inc;
  logic [ALARM_W-1:0] as_inc;
  logic [SECONDS_W-1:0] sit_limit;
  logic [8:0]         walk_limit;
  logic [COUNT_W-1:0] target;
  logic [AVG_W-1:0]   avg;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_threshold  <= RST_THRESHOLD;
      sitting_minutes <= RST_SIT_MINUTES;
      walking_minutes <= RST_WALK_MINUTES;
      mute_delay      <= RST_MUTE_DELAY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD:    walk_threshold  <= cfg_data[9:0];
        CFG_SIT_MINUTES:  sitting_minutes <= cfg_data[7:0];
        CFG_WALK_MINUTES: walking_minutes <= cfg_data[2:0];
        CFG_MUTE_DELAY:   mute_delay      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign pop      = (mode == BK_RUN) && !q_empty && out_free;

  assign ss_inc     = (stage_seconds < SECONDS_MAX) ? stage_seconds + 1'b1 : stage_seconds;
  assign phase_inc  = (phase == PW'(SAMPLE_PERIOD_S - 1)) ? '0 : phase + 1'b1;
  assign hs_inc     = (hold_seconds < HOLD_SAT) ? hold_seconds + 1'b1 : hold_seconds;
  assign as_inc     = (alarm_seconds < ALARM_SECONDS_MAX) ? alarm_seconds + 1'b1
                                                          : alarm_seconds;
  assign sit_limit  = SECONDS_W'(sitting_minutes) * SECONDS_W'(SECONDS_PER_MIN);
  assign walk_limit = 9'(walking_minutes) * 9'(SECONDS_PER_MIN) + 9'(WALK_GRACE_S);
  assign target     = (RAW_TARGET[walking_minutes] > MAX_READINGS)
                      ? COUNT_W'(MAX_READINGS) : COUNT_W'(RAW_TARGET[walking_minutes]);
  // no readings taken: average is zero whatever the divider holds
  assign avg        = (reading_count == '0) ? '0 : div_rsp.quotient[AVG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) mode <= BK_RUN;
    else     mode <= mode_next;
  end

  always_comb begin
    mode_next             = mode;
    stage_next            = stage;
    stage_seconds_next    = stage_seconds;
    phase_next            = phase;
    alarm_seconds_next    = alarm_seconds;
    sound_enabled_next    = sound_enabled;
    hold_pending_next     = hold_pending;
    hold_seconds_next     = hold_seconds;
    intensity_latest_next = intensity_latest;
    led_latest_next       = led_latest;
    activity_sum_next     = activity_sum;
    reading_count_next    = reading_count;
    last_average_next     = last_average;
    emit                  = 1'b0;
    ev                    = EV_NONE;
    enter                 = 1'b0;
    enter_target          = ST_SIT;
    div_req.start         = 1'b0;
    div_req.dividend      = '0;
    div_req.divisor       = '0;

    unique case (mode)
      BK_RUN: begin
        if (pop) begin
          emit = 1'b1;
          if (q_head.opcode == OP_SAMPLE) begin
            intensity_latest_next = q_head.intensity;
            led_latest_next       = q_head.led;
          end else begin
            stage_seconds_next = ss_inc;
            phase_next         = phase_inc;
            unique case (stage)
              ST_SIT: begin
                if (ss_inc >= sit_limit) begin
                  enter        = 1'b1;
                  enter_target = ST_ALARM;
                  ev           = EV_ALARM_START;
                end else if (hold_pending) begin
                  hold_seconds_next = hs_inc;
                  if (hs_inc >= HOLD_W'(HOLD_SECONDS)) begin
                    hold_pending_next = 1'b0;
                    hold_seconds_next = '0;
                    if (q_head.button_pressed) begin
                      enter        = 1'b1;
                      enter_target = ST_ALARM;
                      ev           = EV_ALARM_START;
                    end
                  end
                end else if (q_head.button_pressed) begin
                  hold_pending_next = 1'b1;
                  hold_seconds_next = '0;
                end
              end
              ST_ALARM: begin
                alarm_seconds_next = as_inc;
                // mute first, a press on the same tick still starts the walk
                if (sound_enabled && as_inc >= mute_delay) begin
                  sound_enabled_next = 1'b0;
                  ev                 = EV_MUTED;
                end
                if (q_head.button_pressed) begin
                  enter        = 1'b1;
                  enter_target = ST_WALK;
                  ev           = EV_WALK_START;
                end
              end
              ST_WALK: begin
                if (phase_inc == '0 && reading_count < target) begin
                  activity_sum_next  = activity_sum + SUM_W'(intensity_latest);
                  reading_count_next = reading_count + 1'b1;
                end
                if (ss_inc >= SECONDS_W'(walk_limit)) begin
                  // result waits for the average
                  emit             = 1'b0;
                  mode_next        = BK_DIV;
                  div_req.start    = 1'b1;
                  div_req.dividend = activity_sum_next;
                  div_req.divisor  = reading_count_next;
                end
              end
              default: begin
                enter        = 1'b1;
                enter_target = ST_SIT;
              end
            endcase
          end
        end
      end
      BK_DIV: begin
        if (div_rsp.done && out_free) begin
          emit              = 1'b1;
          mode_next         = BK_RUN;
          last_average_next = avg;
          enter             = 1'b1;
          if (avg > walk_threshold) begin
            enter_target = ST_SIT;
            ev           = EV_SUFFICIENT;
          end else begin
            enter_target = ST_ALARM;
            ev           = EV_INSUFFICIENT;
          end
        end
      end
      default: mode_next = BK_RUN;
    endcase

    if (enter) begin
      stage_next         = enter_target;
      stage_seconds_next = '0;
      phase_next         = '0;
      hold_pending_next  = 1'b0;
      hold_seconds_next  = '0;
      if (enter_target == ST_ALARM) begin
        alarm_seconds_next = '0;
        sound_enabled_next = 1'b1;
      end else begin
        sound_enabled_next = 1'b0;
      end
      if (enter_target == ST_WALK) begin
        activity_sum_next  = '0;
        reading_count_next = '0;
      end
    end

    out_data_next.stage_now        = stage_next;
    out_data_next.sound_on         = (stage_next == ST_ALARM) && sound_enabled_next;
    out_data_next.event_code       = ev;
    out_data_next.activity_average = last_average_next;
    out_data_next.led_level        = led_latest_next;

    if (emit)          out_valid_next = 1'b1;
    else if (out_free) out_valid_next = 1'b0;
    else               out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage            <= ST_SIT;
      stage_seconds    <= '0;
      phase            <= '0;
      alarm_seconds    <= '0;
      sound_enabled    <= 1'b0;
      hold_pending     <= 1'b0;
      hold_seconds     <= '0;
      intensity_latest <= '0;
      led_latest       <= '0;
      activity_sum     <= '0;
      reading_count    <= '0;
      last_average     <= '0;
      out_valid        <= 1'b0;
    end else begin
      stage            <= stage_next;
      stage_seconds    <= stage_seconds_next;
      phase            <= phase_next;
      alarm_seconds    <= alarm_seconds_next;
      sound_enabled    <= sound_enabled_next;
      hold_pending     <= hold_pending_next;
      hold_seconds     <= hold_seconds_next;
      intensity_latest <= intensity_latest_next;
      led_latest       <= led_latest_next;
      activity_sum     <= activity_sum_next;
      reading_count    <= reading_count_next;
      last_average     <= last_average_next;
      out_valid        <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data <= out_data_next;
  end

endmodule

[hw/rtl/sedentary_break_monitor.sv]
// sedentary_break_monitor: top level of the sitting / alarm / walking reminder
// depends on sbm_pkg, sbm_front, sbm_queue, sbm_divider, sbm_back
//
// input channel (in_valid / in_stall / in_data) takes one-second ticks with the
// button level, or gyro samples; every request gives exactly one result on the
// output channel (out_valid / out_stall / out_data), in order.
// configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge (0 threshold, 1 sitting minutes, 2 walking minutes, 3 mute delay);
// write only while no request is in flight.
// path: a request passes three front stages, the queue and the result register
// before out_valid rises. the tick that ends a walk period runs the average
// through the bit-serial divider first; the back holds the queue during that
// time while the front keeps filling it. throughput: one request per cycle
// while out_stall is low, except the walk-ending tick as above.
// a stalled result stays in the output register; the four-entry queue and the
// front pipeline absorb further requests before in_stall rises.
// reset (rst, synchronous): stage sitting, all timers and sums cleared,
// registers back to 250 / 30 / 1 / 3, no result pending.
module sedentary_break_monitor
  import sbm_pkg::*;
#(
  parameter int SAMPLE_PERIOD_S = 2,
  parameter int MAX_READINGS    = 150,
  parameter int HOLD_SECONDS    = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic     push, q_full, q_empty, pop;
  q_item_t  push_item, q_head;
  div_req_t div_req;
  div_rsp_t div_rsp;

  sbm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  sbm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  sbm_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  sbm_back #(
    .SAMPLE_PERIOD_S (SAMPLE_PERIOD_S),
    .MAX_READINGS    (MAX_READINGS),
    .HOLD_SECONDS    (HOLD_SECONDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // buzzer only sounds in alarm
  a_sound_in_alarm: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sound_on |-> out_data.stage_now == ST_ALARM)
    else $error("sound on outside alarm stage");

  a_alarm_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_code == EV_ALARM_START
    |-> out_data.stage_now == ST_ALARM && out_data.sound_on)
    else $error("alarm start without sounding alarm");

  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_code == EV_WALK_START |-> out_data.stage_now == ST_WALK)
    else $error("walk start not in walking stage");

  a_check_stage: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.event_code == EV_SUFFICIENT
                  || out_data.event_code == EV_INSUFFICIENT)
    |-> out_data.stage_now != ST_WALK)
    else $error("walk check left the stage in walking");

  a_led_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.led_level <= LED_MAX)
    else $error("led level above full scale");

endmodule
